// ----- sv/cia_pkg.sv -----
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and register map codes for the interface adapter.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned TEN_W  = 4;
    localparam int unsigned SEC_W  = 7;
    localparam int unsigned MIN_W  = 7;
    localparam int unsigned HR_W   = 5;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [ADDR_W-1:0] REG_PRA     = 4'h0;
    localparam logic [ADDR_W-1:0] REG_PRB     = 4'h1;
    localparam logic [ADDR_W-1:0] REG_DDRA    = 4'h2;
    localparam logic [ADDR_W-1:0] REG_DDRB    = 4'h3;
    localparam logic [ADDR_W-1:0] REG_TA_LO   = 4'h4;
    localparam logic [ADDR_W-1:0] REG_TA_HI   = 4'h5;
    localparam logic [ADDR_W-1:0] REG_TB_LO   = 4'h6;
    localparam logic [ADDR_W-1:0] REG_TB_HI   = 4'h7;
    localparam logic [ADDR_W-1:0] REG_TOD_TEN = 4'h8;
    localparam logic [ADDR_W-1:0] REG_TOD_SEC = 4'h9;
    localparam logic [ADDR_W-1:0] REG_TOD_MIN = 4'hA;
    localparam logic [ADDR_W-1:0] REG_TOD_HR  = 4'hB;
    localparam logic [ADDR_W-1:0] REG_SDR     = 4'hC;
    localparam logic [ADDR_W-1:0] REG_ICR     = 4'hD;
    localparam logic [ADDR_W-1:0] REG_CRA     = 4'hE;
    localparam logic [ADDR_W-1:0] REG_CRB     = 4'hF;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] reg_addr;
        logic [DATA_W-1:0] write_data;
    } t_cia_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_out;
    } t_cia_result;

endpackage

// ----- sv/cia_in_reg.sv -----
// ----------------------------------------------------------------------------
// cia_in_reg
// Input register stage, holds one transaction until the core executes it.
// ----------------------------------------------------------------------------
module cia_in_reg
    import cia_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_cia_item i_item,
    input  logic      i_take,
    output logic      o_valid,
    output t_cia_item o_item
);

    logic      r_valid;
    t_cia_item r_item;
    logic      load;

    assign load    = !r_valid || i_take;
    assign o_stall = !load;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- sv/cia_core.sv -----
// ----------------------------------------------------------------------------
// cia_core
// Register file, time-of-day latch and timer A; executes one transaction.
// ----------------------------------------------------------------------------
module cia_core
    import cia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_exec,
    input  t_cia_item   i_item,
    output t_cia_result o_result
);

    logic [DATA_W-1:0] r_pra, n_pra, r_prb, n_prb, r_ddra, n_ddra, r_ddrb, n_ddrb;
    logic [CNT_W-1:0]  r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [TEN_W-1:0]  r_ten, n_ten, r_h_ten, n_h_ten;
    logic [SEC_W-1:0]  r_sec, n_sec, r_h_sec, n_h_sec;
    logic [MIN_W-1:0]  r_min, n_min, r_h_min, n_h_min;
    logic [HR_W-1:0]   r_hr, n_hr, r_h_hr, n_h_hr;
    logic              r_held, n_held;
    logic [DATA_W-1:0] r_sdr, n_sdr, r_icr, n_icr, r_cra, n_cra, r_crb, n_crb;
    logic              r_irq, n_irq;
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] d;

    assign d = i_item.write_data;

    always_comb begin
        n_pra = r_pra; n_prb = r_prb; n_ddra = r_ddra; n_ddrb = r_ddrb;
        n_cnt_a = r_cnt_a; n_cnt_b = r_cnt_b;
        n_ten = r_ten; n_sec = r_sec; n_min = r_min; n_hr = r_hr;
        n_h_ten = r_h_ten; n_h_sec = r_h_sec; n_h_min = r_h_min; n_h_hr = r_h_hr;
        n_held = r_held;
        n_sdr = r_sdr; n_icr = r_icr; n_cra = r_cra; n_crb = r_crb;
        n_irq = r_irq;
        rd = '0;
        if (i_exec) begin
            case (i_item.cmd)
                CMD_READ: begin
                    case (i_item.reg_addr)
                        REG_PRA:   rd = r_pra & r_ddra;
                        REG_PRB:   rd = r_prb & r_ddrb;
                        REG_DDRA:  rd = r_ddra;
                        REG_DDRB:  rd = r_ddrb;
                        REG_TA_LO: rd = r_cnt_a[7:0];
                        REG_TA_HI: rd = r_cnt_a[15:8];
                        REG_TB_LO: rd = r_cnt_b[7:0];
                        REG_TB_HI: rd = r_cnt_b[15:8];
                        REG_TOD_TEN: begin
                            if (!r_held) begin
                                n_h_ten = r_ten;
                                n_h_sec = r_sec;
                                n_h_min = r_min;
                                n_h_hr  = r_hr;
                                n_held  = 1'b1;
                                rd = {{(DATA_W-TEN_W){1'b0}}, r_ten};
                            end else begin
                                rd = {{(DATA_W-TEN_W){1'b0}}, r_h_ten};
                            end
                        end
                        REG_TOD_SEC: rd = {1'b0, (r_held ? r_h_sec : r_sec)};
                        REG_TOD_MIN: rd = {1'b0, (r_held ? r_h_min : r_min)};
                        REG_TOD_HR: begin
                            rd = {{(DATA_W-HR_W){1'b0}}, (r_held ? r_h_hr : r_hr)};
                            n_held = 1'b0;
                        end
                        REG_SDR: rd = '0;
                        REG_ICR: begin
                            rd = r_icr;
                            n_icr = '0;
                        end
                        REG_CRA: rd = r_cra;
                        default: rd = r_crb;
                    endcase
                end
                CMD_WRITE: begin
                    case (i_item.reg_addr)
                        REG_PRA:   n_pra = d;
                        REG_PRB:   n_prb = d;
                        REG_DDRA:  n_ddra = d;
                        REG_DDRB:  n_ddrb = d;
                        REG_TA_LO: n_cnt_a = {r_cnt_a[15:8], d};
                        REG_TA_HI: n_cnt_a = {d, r_cnt_a[7:0]};
                        REG_TB_LO: n_cnt_b = {r_cnt_b[15:8], d};
                        REG_TB_HI: n_cnt_b = {d, r_cnt_b[7:0]};
                        REG_TOD_TEN: begin
                            n_ten  = d[TEN_W-1:0];
                            n_held = 1'b0;
                        end
                        REG_TOD_SEC: n_sec = d[SEC_W-1:0];
                        REG_TOD_MIN: n_min = d[MIN_W-1:0];
                        REG_TOD_HR:  n_hr = d[HR_W-1:0];
                        REG_SDR:     n_sdr = d;
                        REG_ICR:     n_icr = d;
                        REG_CRA:     n_cra = d;
                        default:     n_crb = d;
                    endcase
                end
                CMD_TICK: begin
                    if (r_cra[0]) begin
                        if (r_cnt_a == '0) begin
                            n_icr[0] = 1'b1;
                            if (r_sdr[0]) begin
                                n_irq = 1'b1;
                            end
                        end else begin
                            n_cnt_a = r_cnt_a - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result.read_data = rd;
    assign o_result.irq_out   = n_irq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pra <= '0; r_prb <= '0; r_ddra <= '0; r_ddrb <= '0;
            r_cnt_a <= '0; r_cnt_b <= '0;
            r_ten <= '0; r_sec <= '0; r_min <= '0; r_hr <= '0;
            r_h_ten <= '0; r_h_sec <= '0; r_h_min <= '0; r_h_hr <= '0;
            r_held <= 1'b0;
            r_sdr <= '0; r_icr <= '0; r_cra <= '0; r_crb <= '0;
            r_irq <= 1'b0;
        end else begin
            r_pra <= n_pra; r_prb <= n_prb; r_ddra <= n_ddra; r_ddrb <= n_ddrb;
            r_cnt_a <= n_cnt_a; r_cnt_b <= n_cnt_b;
            r_ten <= n_ten; r_sec <= n_sec; r_min <= n_min; r_hr <= n_hr;
            r_h_ten <= n_h_ten; r_h_sec <= n_h_sec; r_h_min <= n_h_min; r_h_hr <= n_h_hr;
            r_held <= n_held;
            r_sdr <= n_sdr; r_icr <= n_icr; r_cra <= n_cra; r_crb <= n_crb;
            r_irq <= n_irq;
        end
    end

endmodule

// ----- sv/cia_out_reg.sv -----
// ----------------------------------------------------------------------------
// cia_out_reg
// Result register, holds one result transaction until it is taken.
// ----------------------------------------------------------------------------
module cia_out_reg
    import cia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cia_result i_result,
    output logic        o_take,
    output logic        o_valid,
    input  logic        i_stall,
    output t_cia_result o_result
);

    logic        r_valid;
    t_cia_result r_result;

    assign o_take   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- sv/complex_interface_adapter_regs.sv -----
// ----------------------------------------------------------------------------
// complex_interface_adapter_regs
// Reduced interface adapter: sixteen-register map, time-of-day latch, timer A.
//
//   channel  direction  handshake             payload
//   in       input      i_in_valid/o_in_stall i_cmd, i_reg_addr, i_write_data
//   out      output     o_out_valid/i_out_stall o_read_data, o_irq_out
//
// one transaction per cycle sustained unless the result stalls; an accepted item
// moves from the input register to the result register, updating state in one pass
// synchronous active-low reset clears the core state and both valid flags
// a stalled result holds the pipe; the input stalls only when both stages are full
// ----------------------------------------------------------------------------
module complex_interface_adapter_regs
    import cia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [ADDR_W-1:0] i_reg_addr,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_irq_out
);

    t_cia_item   in_item;
    t_cia_item   ex_item;
    logic        ex_valid;
    logic        take;
    t_cia_result ex_result;
    t_cia_result out_result;

    assign in_item.cmd        = i_cmd;
    assign in_item.reg_addr   = i_reg_addr;
    assign in_item.write_data = i_write_data;

    cia_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (ex_valid),
        .o_item  (ex_item)
    );

    cia_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_exec   (ex_valid && take),
        .i_item   (ex_item),
        .o_result (ex_result)
    );

    cia_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (ex_valid),
        .i_result (ex_result),
        .o_take   (take),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_read_data = out_result.read_data;
    assign o_irq_out   = out_result.irq_out;

endmodule

// ----- sv/cia_checker.sv -----
// ----------------------------------------------------------------------------
// cia_checker
// Port-level checks on the interface adapter, bound to the top level.
// ----------------------------------------------------------------------------
module cia_checker
    import cia_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DATA_W-1:0] o_read_data,
    input logic              o_irq_out
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;
    logic       r_seen_irq;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_seen_irq <= 1'b0;
        end else begin
            r_pending <= r_pending + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc && o_irq_out) begin
                r_seen_irq <= 1'b1;
            end
        end
    end

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data)
            && $stable(o_irq_out))
        else $error("stalled result changed");

    // interrupt line is sticky across results
    a_irq_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen_irq |-> o_irq_out)
        else $error("interrupt line dropped");

    // at most two transactions in flight
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("too many transactions in flight");

    // input only stalls when a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without backpressure");

    // a result needs a prior accepted transaction
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd0 |-> !o_out_valid)
        else $error("result without transaction");

endmodule

bind complex_interface_adapter_regs cia_checker u_cia_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_read_data (o_read_data),
    .o_irq_out   (o_irq_out)
);

// ----- tb/tb_complex_interface_adapter_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_interface_adapter_regs
// Self-checking bench for the interface adapter register block. Directed
// accesses cover the register map, the time-of-day latch and the sticky
// interrupt line. Random access sequences run under three idling
// mixes and one long output hold-off. A behavioral model of the register
// state predicts every result, and each received result is compared with it.
// ----------------------------------------------------------------------------
module tb_complex_interface_adapter_regs;
    import cia_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
    localparam int unsigned      HOLD_CYCLES    = 80;
    localparam int unsigned      WATCHDOG_LIMIT = 2000;
    localparam int unsigned      DRAIN_CYCLES   = 8;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_cmd        = '0;
    logic [ADDR_W-1:0] i_reg_addr   = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic              o_irq_out;

    // register state of the model
    logic [DATA_W-1:0] pa_data = '0, pb_data = '0, pa_dir = '0, pb_dir = '0;
    logic [CNT_W-1:0]  timer_a = '0, timer_b = '0;
    logic [TEN_W-1:0]  tod_ten = '0;
    logic [SEC_W-1:0]  tod_sec = '0;
    logic [MIN_W-1:0]  tod_min = '0;
    logic [HR_W-1:0]   tod_hr  = '0;
    logic [6:0]        tod_hold [4] = '{default: '0};
    logic              tod_held = 1'b0;
    logic [DATA_W-1:0] sdr = '0, icr = '0, cra = '0, crb = '0;
    logic              irq_sticky = 1'b0;

    t_cia_result expected_results [$];
    t_cia_result want;

    int unsigned err_count     = 0;
    int unsigned items_sent    = 0;
    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;
    int unsigned quiet_left    = 0;
    int unsigned hold_req_cnt  = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;

    complex_interface_adapter_regs dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_reg_addr  (i_reg_addr),
        .i_write_data(i_write_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_data (o_read_data),
        .o_irq_out   (o_irq_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_cia_result predict_access(input logic [CMD_W-1:0] cmd,
                                                   input logic [ADDR_W-1:0] addr,
                                                   input logic [DATA_W-1:0] data);
        t_cia_result res;
        res.read_data = '0;
        if (cmd == CMD_READ) begin
            case (addr)
                REG_PRA:     res.read_data = pa_data & pa_dir;
                REG_PRB:     res.read_data = pb_data & pb_dir;
                REG_DDRA:    res.read_data = pa_dir;
                REG_DDRB:    res.read_data = pb_dir;
                REG_TA_LO:   res.read_data = timer_a[7:0];
                REG_TA_HI:   res.read_data = timer_a[15:8];
                REG_TB_LO:   res.read_data = timer_b[7:0];
                REG_TB_HI:   res.read_data = timer_b[15:8];
                REG_TOD_TEN: begin
                    if (!tod_held) begin
                        tod_hold[0] = 7'(tod_ten);
                        tod_hold[1] = tod_sec;
                        tod_hold[2] = tod_min;
                        tod_hold[3] = 7'(tod_hr);
                        tod_held    = 1'b1;
                    end
                    res.read_data = 8'(tod_hold[0]);
                end
                REG_TOD_SEC: res.read_data = tod_held ? 8'(tod_hold[1]) : 8'(tod_sec);
                REG_TOD_MIN: res.read_data = tod_held ? 8'(tod_hold[2]) : 8'(tod_min);
                REG_TOD_HR: begin
                    res.read_data = tod_held ? 8'(tod_hold[3]) : 8'(tod_hr);
                    tod_held = 1'b0;
                end
                REG_SDR:     res.read_data = '0;
                REG_ICR: begin
                    res.read_data = icr;
                    icr = '0;
                end
                REG_CRA:     res.read_data = cra;
                default:     res.read_data = crb;
            endcase
        end else if (cmd == CMD_WRITE) begin
            case (addr)
                REG_PRA:     pa_data = data;
                REG_PRB:     pb_data = data;
                REG_DDRA:    pa_dir = data;
                REG_DDRB:    pb_dir = data;
                REG_TA_LO:   timer_a[7:0] = data;
                REG_TA_HI:   timer_a[15:8] = data;
                REG_TB_LO:   timer_b[7:0] = data;
                REG_TB_HI:   timer_b[15:8] = data;
                REG_TOD_TEN: begin
                    tod_ten  = data[TEN_W-1:0];
                    tod_held = 1'b0;
                end
                REG_TOD_SEC: tod_sec = data[SEC_W-1:0];
                REG_TOD_MIN: tod_min = data[MIN_W-1:0];
                REG_TOD_HR:  tod_hr = data[HR_W-1:0];
                REG_SDR:     sdr = data;
                REG_ICR:     icr = data;
                REG_CRA:     cra = data;
                default:     crb = data;
            endcase
        end else if (cmd == CMD_TICK && cra[0]) begin
            if (timer_a == '0) begin
                icr[0] = 1'b1;
                if (sdr[0]) begin
                    irq_sticky = 1'b1;
                end
            end else begin
                timer_a = timer_a - 1'b1;
            end
        end
        res.irq_out = irq_sticky;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] exp_val);
        $display("%0t: mismatch, %s: got %02h expected %02h", $realtime, what, got, exp_val);
        err_count++;
    endtask

    task automatic send_access(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
        if (quiet_left != 0) begin
            quiet_left--;
        end else if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_reg_addr   <= addr;
        i_write_data <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_access(cmd, addr, data));
        items_sent++;
    endtask

    task automatic send_random_access(input bit allow_irq);
        int unsigned       sel;
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        sel  = $urandom_range(99);
        cmd  = sel < 40 ? CMD_READ : sel < 72 ? CMD_WRITE : sel < 95 ? CMD_TICK : CMD_UNUSED;
        addr = ADDR_W'($urandom_range(15));
        data = DATA_W'($urandom_range(255));
        // keep the sticky line low until its own test
        if (!allow_irq && cmd == CMD_WRITE && addr == REG_SDR) begin
            data[0] = 1'b0;
        end
        send_access(cmd, addr, data);
    endtask

    task automatic pause_until_drained;
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_register_map;
        send_access(CMD_WRITE, REG_DDRA, 8'hff);
        send_access(CMD_WRITE, REG_PRA, 8'ha5);
        send_access(CMD_READ, REG_PRA, 8'h00);
        send_access(CMD_WRITE, REG_DDRB, 8'h0f);
        send_access(CMD_WRITE, REG_PRB, 8'hff);
        send_access(CMD_READ, REG_PRB, 8'hff);
        send_access(CMD_READ, REG_DDRB, 8'h00);
        send_access(CMD_WRITE, REG_TB_LO, 8'hff);
        send_access(CMD_WRITE, REG_TB_HI, 8'hff);
        send_access(CMD_READ, REG_TB_HI, 8'h00);
        send_access(CMD_WRITE, REG_ICR, 8'hff);
        send_access(CMD_READ, REG_ICR, 8'h00);
        send_access(CMD_READ, REG_ICR, 8'h00);
        send_access(CMD_WRITE, REG_CRB, 8'h80);
        send_access(CMD_READ, REG_CRB, 8'hff);
        send_access(CMD_READ, REG_SDR, 8'h00);
        send_access(CMD_UNUSED, REG_CRB, 8'hff);
    endtask

    task automatic test_tod_latch;
        send_access(CMD_WRITE, REG_TOD_TEN, 8'hff);
        send_access(CMD_WRITE, REG_TOD_SEC, 8'hff);
        send_access(CMD_WRITE, REG_TOD_MIN, 8'hff);
        send_access(CMD_WRITE, REG_TOD_HR, 8'hff);
        send_access(CMD_READ, REG_TOD_TEN, 8'h00);
        send_access(CMD_WRITE, REG_TOD_SEC, 8'h00);
        send_access(CMD_READ, REG_TOD_SEC, 8'h00);
        send_access(CMD_READ, REG_TOD_MIN, 8'h00);
        send_access(CMD_READ, REG_TOD_HR, 8'h00);
        send_access(CMD_READ, REG_TOD_SEC, 8'h00);
    endtask

    task automatic test_sticky_irq;
        send_access(CMD_WRITE, REG_SDR, 8'h01);
        send_access(CMD_WRITE, REG_TA_LO, 8'h01);
        send_access(CMD_WRITE, REG_TA_HI, 8'h00);
        send_access(CMD_WRITE, REG_CRA, 8'h01);
        send_access(CMD_TICK, REG_PRA, 8'h00);
        send_access(CMD_TICK, REG_PRA, 8'h00);
        send_access(CMD_READ, REG_ICR, 8'h00);
        send_access(CMD_READ, REG_ICR, 8'h00);
        send_access(CMD_TICK, REG_PRA, 8'h00);
        send_access(CMD_READ, REG_ICR, 8'h00);
    endtask

    task automatic test_random_traffic(input int unsigned in_pct, input int unsigned out_pct,
                                       input int unsigned n_items, input bit allow_irq);
        int unsigned       start;
        int unsigned       a;
        logic [ADDR_W-1:0] addr;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        start         = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(39) == 0) begin
                quiet_left = 30;
            end
            case ($urandom_range(9))
                6: begin
                    // latched clock readout, sometimes disturbed by a write
                    send_access(CMD_READ, REG_TOD_TEN, DATA_W'($urandom_range(255)));
                    if ($urandom_range(1)) begin
                        addr = REG_TOD_SEC + ADDR_W'($urandom_range(2));
                        send_access(CMD_WRITE, addr, DATA_W'($urandom_range(255)));
                    end
                    send_access(CMD_READ, REG_TOD_SEC, DATA_W'($urandom_range(255)));
                    send_access(CMD_READ, REG_TOD_MIN, DATA_W'($urandom_range(255)));
                    send_access(CMD_READ, REG_TOD_HR, DATA_W'($urandom_range(255)));
                end
                7: begin
                    // timer loaded with a small count and ticked down
                    send_access(CMD_WRITE, REG_TA_LO, DATA_W'($urandom_range(6)));
                    send_access(CMD_WRITE, REG_TA_HI,
                                $urandom_range(7) == 0 ? DATA_W'($urandom_range(255)) : '0);
                    send_access(CMD_WRITE, REG_CRA, DATA_W'($urandom_range(255)) | 8'h01);
                    repeat ($urandom_range(1, 10)) begin
                        send_access(CMD_TICK, ADDR_W'($urandom_range(15)),
                                    DATA_W'($urandom_range(255)));
                    end
                    send_access(CMD_READ, REG_ICR, DATA_W'($urandom_range(255)));
                end
                8: begin
                    for (int k = 0; k < 4; k++) begin
                        send_access(CMD_WRITE, REG_TOD_TEN + ADDR_W'(k),
                                    DATA_W'($urandom_range(255)));
                    end
                    send_access(CMD_READ, REG_TOD_TEN + ADDR_W'($urandom_range(3)),
                                DATA_W'($urandom_range(255)));
                end
                9: begin
                    a = $urandom_range(1);
                    send_access(CMD_WRITE, REG_DDRA + ADDR_W'(a), DATA_W'($urandom_range(255)));
                    send_access(CMD_WRITE, REG_PRA + ADDR_W'(a), DATA_W'($urandom_range(255)));
                    send_access(CMD_READ, REG_PRA + ADDR_W'(a), DATA_W'($urandom_range(255)));
                end
                default: send_random_access(allow_irq);
            endcase
        end
    endtask

    task automatic test_backpressure;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_req_cnt++;
        repeat (30) send_random_access(1'b0);
        pause_until_drained();
    endtask

    // receiver: random stall, plus long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_seen != hold_req_cnt) begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (quiet_left == 0 && $urandom_range(99) < out_stall_pct) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no transaction pending", o_read_data, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    report_mismatch("read_data", o_read_data, want.read_data);
                end
                if (o_irq_out !== want.irq_out) begin
                    report_mismatch("irq_out", 8'(o_irq_out), 8'(want.irq_out));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_map();
        test_tod_latch();
        test_random_traffic(8, 46, 500, 1'b0);
        test_random_traffic(46, 8, 500, 1'b0);
        test_backpressure();
        test_sticky_irq();
        test_random_traffic(0, 0, 500, 1'b1);
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
